// ----- rtl/core/ccu_pkg.sv -----
package ccu_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FN_ATAN    = 3'd0;
    localparam logic [2:0] FN_MAG     = 3'd1;
    localparam logic [2:0] FN_SINCOS  = 3'd2;
    localparam logic [2:0] FN_ASIN    = 3'd3;
    localparam logic [2:0] FN_ACOS    = 3'd4;

    // Steering rule that a cell applies to pick its direction.
    typedef enum logic [1:0] {
        MODE_VEC  = 2'd0,
        MODE_ROT  = 2'd1,
        MODE_ASIN = 2'd2,
        MODE_ACOS = 2'd3
    } t_mode;

    // Reduction of the integer degrees modulo 360 is split into a pass-through of the
    // low three bits and a reduction modulo 45 by reciprocal multiplication.
    localparam int MOD_UW     = 22;
    localparam int MOD_MW     = 23;
    localparam int MOD_QW     = 17;
    localparam int MOD_SHIFT  = 28;
    localparam int MOD_MUL    = 5965233;
    localparam int MOD_OFFSET = 1048590;
    localparam int MOD_DIV    = 45;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_a;
        logic signed [31:0] result_b;
    } t_out;

    typedef struct packed {
        t_in                item;
        logic [MOD_UW-1:0]  u;
        logic [MOD_QW-1:0]  quot;
    } t_red;

    typedef struct packed {
        t_mode              mode;
        logic [2:0]         func;
        logic               neg;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] target;
    } t_cell;

    function automatic logic signed [31:0] deg_fp(input int deg, input int fb);
        return 32'(longint'(deg) <<< fb);
    endfunction

    function automatic logic signed [31:0] gain_fp(input int fb);
        return 32'(((longint'(607253) <<< fb) + 500000) / 1000000);
    endfunction

    // Angle step i in degrees, scaled by ten thousand before conversion.
    function automatic logic signed [31:0] angle_fp(input int idx, input int fb);
        longint a;
        unique case (idx)
            0:       a = 450000;
            1:       a = 265651;
            2:       a = 140362;
            3:       a = 71250;
            4:       a = 35763;
            5:       a = 17899;
            6:       a = 8952;
            7:       a = 4476;
            8:       a = 2238;
            9:       a = 1119;
            10:      a = 560;
            11:      a = 280;
            12:      a = 140;
            13:      a = 70;
            default: a = 35;
        endcase
        return 32'(((a <<< fb) + 5000) / 10000);
    endfunction

endpackage

// ----- rtl/core/ccu_prep.sv -----
module ccu_prep #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ccu_pkg::t_in  i_item,
    output logic          o_ready,
    output logic          o_valid,
    output ccu_pkg::t_cell o_cell,
    input  logic          i_ready
);
    import ccu_pkg::*;

    localparam logic signed [31:0] DEG90  = deg_fp(90, FRACTION_BITS);
    localparam logic signed [31:0] DEG180 = deg_fp(180, FRACTION_BITS);
    localparam logic signed [31:0] DEG270 = deg_fp(270, FRACTION_BITS);
    localparam logic signed [31:0] DEG360 = deg_fp(360, FRACTION_BITS);
    localparam logic signed [31:0] GAIN   = gain_fp(FRACTION_BITS);
    localparam int PW = MOD_UW + MOD_MW;

    logic  r_v1, r_v2, ready1, ready2;
    t_red  r_red, n_red;
    t_cell r_cell, n_cell;

    logic signed [31:0] q_hi, q_div8, th, a, b;
    logic [MOD_UW-1:0]  u, rem_wide;
    logic [PW-1:0]      prod;
    logic [8:0]         deg;

    assign ready2  = !r_v2 || i_ready;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign o_valid = r_v2;
    assign o_cell  = r_cell;

    // First stage: whole degrees, then the quotient by 45 of their eighth.
    always_comb begin
        q_hi        = i_item.operand_a >>> FRACTION_BITS;
        q_div8      = q_hi >>> 3;
        u           = MOD_UW'(q_div8 + MOD_OFFSET);
        prod        = PW'(u) * PW'(MOD_MUL);
        n_red.item  = i_item;
        n_red.u     = u;
        n_red.quot  = prod[MOD_SHIFT +: MOD_QW];
    end

    // Second stage: remainder, reduced angle and the starting vector.
    always_comb begin
        a        = r_red.item.operand_a;
        b        = r_red.item.operand_b;
        rem_wide = r_red.u - MOD_UW'(MOD_UW'(r_red.quot) * MOD_UW'(MOD_DIV));
        deg      = {rem_wide[5:0], a[FRACTION_BITS +: 3]};
        th       = $signed(32'({deg, a[FRACTION_BITS-1:0]}));

        n_cell.func   = r_red.item.func;
        n_cell.mode   = MODE_VEC;
        n_cell.neg    = 1'b0;
        n_cell.x      = b;
        n_cell.y      = a;
        n_cell.z      = '0;
        n_cell.target = a;
        unique case (r_red.item.func)
            FN_ATAN: begin
                if (b < 0) begin
                    n_cell.x = -b;
                    n_cell.y = -a;
                end
            end
            FN_MAG: begin
                n_cell.x = (b < 0) ? -b : b;
                n_cell.y = (a < 0) ? -a : a;
            end
            FN_SINCOS: begin
                n_cell.mode   = MODE_ROT;
                n_cell.x      = GAIN;
                n_cell.y      = '0;
                n_cell.target = th;
                n_cell.neg    = (th > DEG90) && (th <= DEG270);
                if (th > DEG270) begin
                    n_cell.z = DEG360;
                end else if (th > DEG90) begin
                    n_cell.z = DEG180;
                end
            end
            FN_ASIN: begin
                n_cell.mode = MODE_ASIN;
                n_cell.x    = GAIN;
                n_cell.y    = '0;
            end
            FN_ACOS: begin
                n_cell.mode = MODE_ACOS;
                n_cell.x    = '0;
                n_cell.y    = GAIN;
                n_cell.z    = DEG90;
            end
            default: begin
                n_cell.mode = MODE_VEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r_red <= n_red;
        end
        if (ready2 && r_v1) begin
            r_cell <= n_cell;
        end
    end

endmodule

// ----- rtl/core/ccu_cell.sv -----
module ccu_cell #(
    parameter int                 SHIFT = 0,
    parameter logic signed [31:0] ANGLE = 32'sd0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ccu_pkg::t_cell i_cell,
    output logic           o_ready,
    output logic           o_valid,
    output ccu_pkg::t_cell o_cell,
    input  logic           i_ready
);
    import ccu_pkg::*;

    logic  r_valid, ready, ccw, add_ang;
    t_cell r_cell, n_cell;
    logic signed [31:0] xs, ys;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_comb begin
        xs = i_cell.x >>> SHIFT;
        ys = i_cell.y >>> SHIFT;
        unique case (i_cell.mode)
            MODE_VEC:  ccw = !(i_cell.y > 0);
            MODE_ROT:  ccw = i_cell.target > i_cell.z;
            MODE_ASIN: ccw = i_cell.y < i_cell.target;
            MODE_ACOS: ccw = i_cell.x > i_cell.target;
            default:   ccw = 1'b0;
        endcase
        // Vectoring accumulates the angle with the opposite sense of the turn.
        add_ang = (i_cell.mode == MODE_VEC) ? !ccw : ccw;

        n_cell   = i_cell;
        n_cell.x = ccw ? (i_cell.x - ys) : (i_cell.x + ys);
        n_cell.y = ccw ? (i_cell.y + xs) : (i_cell.y - xs);
        n_cell.z = add_ang ? (i_cell.z + ANGLE) : (i_cell.z - ANGLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_cell <= n_cell;
        end
    end

endmodule

// ----- rtl/core/ccu_post.sv -----
module ccu_post #(
    parameter int FRACTION_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ccu_pkg::t_cell i_cell,
    output logic           o_ready,
    output logic           o_valid,
    output ccu_pkg::t_out  o_item,
    input  logic           i_ready
);
    import ccu_pkg::*;

    localparam logic signed [31:0] DEG90  = deg_fp(90, FRACTION_BITS);
    localparam logic signed [31:0] DEG180 = deg_fp(180, FRACTION_BITS);
    localparam logic signed [31:0] GAIN   = gain_fp(FRACTION_BITS);

    logic  r_valid, ready;
    t_out  r_item, n_item;
    logic signed [63:0] prod;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        prod            = 64'(i_cell.x) * 64'(GAIN);
        n_item.result_a = '0;
        n_item.result_b = '0;
        unique case (i_cell.func)
            FN_ATAN: begin
                n_item.result_a = i_cell.z;
            end
            FN_MAG: begin
                n_item.result_a = 32'(prod >>> FRACTION_BITS);
            end
            FN_SINCOS: begin
                n_item.result_a = i_cell.neg ? -i_cell.x : i_cell.x;
                n_item.result_b = i_cell.neg ? -i_cell.y : i_cell.y;
            end
            FN_ASIN: begin
                if (i_cell.z < -DEG90) begin
                    n_item.result_a = -DEG90;
                end else if (i_cell.z > DEG90) begin
                    n_item.result_a = DEG90;
                end else begin
                    n_item.result_a = i_cell.z;
                end
            end
            FN_ACOS: begin
                if (i_cell.z < 0) begin
                    n_item.result_a = '0;
                end else if (i_cell.z > DEG180) begin
                    n_item.result_a = DEG180;
                end else begin
                    n_item.result_a = i_cell.z;
                end
            end
            default: begin
                n_item.result_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/core/circular_cordic_unit.sv -----
// Circular CORDIC unit working in degrees, two's complement with FRACTION_BITS fraction bits.
// Input channel: i_in_valid, o_in_stall and i_in_item (func, operand_a, operand_b). A
// transaction is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid, i_out_stall and o_out_item (result_a, result_b). Every
// input transaction yields exactly one output transaction, in order.
// The pipeline is ITERATIONS + 3 register stages deep. When nothing stalls, a transaction
// accepted at an edge moves through the stages in order and then shows on o_out_valid,
// where it stays until it is taken with i_out_stall low. The stages are
// two preparation stages (angle reduction modulo 360 by reciprocal multiply, then the
// starting vector), one stage per CORDIC micro-rotation cell, and one result stage
// that applies the gain multiply, clamping and the quadrant negation.
// Throughput is one transaction per cycle while i_out_stall stays low; every stage is its
// own register and the only loop-carried path is the ready chain along the stages.
// When the receiver stalls, the held result stays on o_out_item while the stages
// behind it keep filling any empty slots, so o_in_stall rises only once every
// stage holds a transaction.
// Reset (i_rst_n low at a clock edge) empties all stages; no result is lost or
// invented after it, and nothing else needs to settle.
module circular_cordic_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int ITERATIONS    = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ccu_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ccu_pkg::t_out o_out_item
);
    import ccu_pkg::*;

    // Stage links: index k feeds cell k, index ITERATIONS feeds the result stage.
    logic  link_valid [ITERATIONS+1];
    logic  link_ready [ITERATIONS+1];
    t_cell link_cell  [ITERATIONS+1];
    logic  prep_ready, post_ready;

    assign o_in_stall = !prep_ready;

    ccu_prep #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_ready (prep_ready),
        .o_valid (link_valid[0]),
        .o_cell  (link_cell[0]),
        .i_ready (link_ready[0])
    );

    // One cell per micro-rotation; each shifts by its own index.
    for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
        ccu_cell #(
            .SHIFT (k),
            .ANGLE (angle_fp(k, FRACTION_BITS))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .i_cell  (link_cell[k]),
            .o_ready (link_ready[k]),
            .o_valid (link_valid[k+1]),
            .o_cell  (link_cell[k+1]),
            .i_ready (link_ready[k+1])
        );
    end

    assign link_ready[ITERATIONS] = post_ready;

    ccu_post #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[ITERATIONS]),
        .i_cell  (link_cell[ITERATIONS]),
        .o_ready (post_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_ready (!i_out_stall)
    );

endmodule

// ----- rtl/core/ccu_checker.sv -----
module ccu_checker #(
    parameter int ITERATIONS = 15
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ccu_pkg::t_out o_out_item
);
    import ccu_pkg::*;

    localparam int DEPTH = ITERATIONS + 3;
    localparam int CW    = $clog2(DEPTH + 2);

    logic [CW-1:0] r_count;
    logic          in_take, out_take;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;

    // Transactions inside the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + CW'(in_take) - CW'(out_take);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or vanished");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_count != 0)
        else $error("result without a pending transaction");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("more transactions in flight than stages");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 0 |-> !o_in_stall)
        else $error("input stalled while the pipeline is empty");

endmodule

bind circular_cordic_unit ccu_checker #(.ITERATIONS(ITERATIONS)) u_ccu_checker (.*);

// ----- tb/testbench.sv -----
module testbench;

    import ccu_pkg::*;

    // The block is built with its default precision, and the predictor below is written
    // for the same fraction width and number of micro-rotations.
    localparam int FB    = 16;
    localparam int ITERS = 15;

    localparam int RANDOM_ITEMS = 1150;
    localparam int MAX_REPORTS  = 10;
    localparam int BURST_LEN    = 150;

    // Highest encoding that the func field can carry; everything above FN_ACOS is unused.
    localparam logic [2:0] FN_TOP = 3'd7;

    // Angles in fixed point degrees.
    localparam int ONE_FP       = 1 << FB;
    localparam int QUARTER_TURN = 90 << FB;
    localparam int HALF_TURN    = 180 << FB;
    localparam int THREE_QUART  = 270 << FB;
    localparam int FULL_TURN    = 360 << FB;

    // Arguments for arcsine and arccosine mostly stay within a little beyond the unit circle.
    localparam int ARC_SPAN = (5 << FB) / 4;

    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

    // atan(2^-i) in units of 1e-4 degree.
    localparam int ATAN_STEPS_E4 [15] = '{
        450000, 265651, 140362, 71250, 35763, 17899, 8952, 4476,
        2238, 1119, 560, 280, 140, 70, 35
    };

    // The scoreboard holds an independent model of the datapath. Each accepted input
    // transaction is turned into the one output transaction that it must produce, and
    // results are checked in order against that queue.
    class cordic_scoreboard;
        t_out               expected_q[$];
        int                 failures;
        logic signed [31:0] step_angle [ITERS];
        logic signed [31:0] gain;

        function new();
            failures = 0;
            gain = 32'(((longint'(607253) << FB) + 500000) / 1000000);
            for (int i = 0; i < ITERS; i++)
                step_angle[i] = 32'(((longint'(ATAN_STEPS_E4[i]) << FB) + 5000) / 10000);
        endfunction

        // One shift-and-add micro-rotation; ccw turns the vector counterclockwise.
        function void micro_rotate(inout logic signed [31:0] x, inout logic signed [31:0] y,
                                   input int i, input bit ccw);
            logic signed [31:0] xs;
            logic signed [31:0] ys;
            xs = x >>> i;
            ys = y >>> i;
            if (ccw) begin
                x = x - ys;
                y = y + xs;
            end else begin
                x = x + ys;
                y = y - xs;
            end
        endfunction

        function t_out predict(t_in it);
            t_out               r;
            logic signed [31:0] x;
            logic signed [31:0] y;
            logic signed [31:0] target;
            int                 angle;
            int                 th;
            longint             prod;
            bit                 ccw;
            r = '0;
            case (it.func)
                FN_ATAN, FN_MAG: begin
                    if (it.func == FN_ATAN) begin
                        // A vector in the left half plane is mirrored through the origin.
                        x = it.operand_b;
                        y = it.operand_a;
                        if (x < 0) begin
                            x = -x;
                            y = -y;
                        end
                    end else begin
                        // The most negative value has no positive twin and stays as it is.
                        x = (it.operand_b < 0) ? -it.operand_b : it.operand_b;
                        y = (it.operand_a < 0) ? -it.operand_a : it.operand_a;
                    end
                    angle = 0;
                    for (int i = 0; i < ITERS; i++) begin
                        ccw = !(y > 0);
                        micro_rotate(x, y, i, ccw);
                        angle += ccw ? -step_angle[i] : step_angle[i];
                    end
                    if (it.func == FN_ATAN) begin
                        r.result_a = angle;
                    end else begin
                        prod = longint'(x) * longint'(gain);
                        prod = prod >>> FB;
                        r.result_a = prod[31:0];
                    end
                end
                FN_SINCOS: begin
                    // Remainder modulo a full turn, lifted into 0 .. 360 when negative.
                    th = int'(it.operand_a) % FULL_TURN;
                    if (th < 0)
                        th += FULL_TURN;
                    angle = 0;
                    if (th > QUARTER_TURN)
                        angle = HALF_TURN;
                    if (th > THREE_QUART)
                        angle = FULL_TURN;
                    x = gain;
                    y = '0;
                    for (int i = 0; i < ITERS; i++) begin
                        ccw = th > angle;
                        micro_rotate(x, y, i, ccw);
                        angle += ccw ? step_angle[i] : -step_angle[i];
                    end
                    // The left half plane, 270 degrees exactly included, flips both results.
                    if (th > QUARTER_TURN && th <= THREE_QUART) begin
                        x = -x;
                        y = -y;
                    end
                    r.result_a = x;
                    r.result_b = y;
                end
                FN_ASIN: begin
                    target = it.operand_a;
                    angle  = 0;
                    x = gain;
                    y = '0;
                    for (int i = 0; i < ITERS; i++) begin
                        ccw = y < target;
                        micro_rotate(x, y, i, ccw);
                        angle += ccw ? step_angle[i] : -step_angle[i];
                    end
                    if (angle < -QUARTER_TURN)
                        angle = -QUARTER_TURN;
                    if (angle > QUARTER_TURN)
                        angle = QUARTER_TURN;
                    r.result_a = angle;
                end
                FN_ACOS: begin
                    target = it.operand_a;
                    angle  = QUARTER_TURN;
                    x = '0;
                    y = gain;
                    for (int i = 0; i < ITERS; i++) begin
                        ccw = x > target;
                        micro_rotate(x, y, i, ccw);
                        angle += ccw ? step_angle[i] : -step_angle[i];
                    end
                    if (angle < 0)
                        angle = 0;
                    if (angle > HALF_TURN)
                        angle = HALF_TURN;
                    r.result_a = angle;
                end
                default: begin
                    // Unused encodings return zero in both fields.
                end
            endcase
            return r;
        endfunction

        function void note_input(t_in it);
            expected_q.push_back(predict(it));
        endfunction

        function void report_failure(string what, t_out want, t_out got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("MISMATCH %s: expected a=%h b=%h, got a=%h b=%h", what,
                         want.result_a, want.result_b, got.result_a, got.result_b);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                report_failure("result without a pending request", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_a !== want.result_a || got.result_b !== want.result_b)
                report_failure("result fields", want, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  o_in_stall;
    t_in   i_in_item   = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_item;

    // While set, neither side inserts idle cycles, so the pipeline runs back to back.
    bit no_idle = 1'b0;

    cordic_scoreboard results_board;

    circular_cordic_unit #(
        .FRACTION_BITS(FB),
        .ITERATIONS   (ITERS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // Number of cycles a side holds back before its next transaction.
    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic t_in make_item(logic [2:0] func, logic signed [31:0] a,
                                      logic signed [31:0] b);
        t_in it;
        it.func      = func;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    // Operands span the full word, mid-sized values, values near one, and the extremes.
    function automatic logic signed [31:0] rand_operand();
        int style;
        style = $urandom_range(0, 9);
        if (style < 4)
            return $urandom;
        if (style < 6)
            return int'($urandom_range(0, 1 << 25)) - (1 << 24);
        if (style < 9)
            return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        case ($urandom_range(0, 4))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in it;
        int  pick;
        int  turns;
        if ($urandom_range(0, 49) == 0)
            it.func = 3'($urandom_range(int'(FN_ACOS) + 1, int'(FN_TOP)));
        else
            it.func = 3'($urandom_range(int'(FN_ATAN), int'(FN_ACOS)));
        it.operand_a = rand_operand();
        it.operand_b = rand_operand();
        pick = $urandom_range(0, 9);
        if (it.func == FN_SINCOS && pick < 5) begin
            // Land on or right next to a quadrant boundary, within two full turns.
            turns = int'($urandom_range(0, 16)) - 8;
            it.operand_a = turns * QUARTER_TURN + int'($urandom_range(0, 4)) - 2;
        end else if (it.func == FN_SINCOS && pick < 8) begin
            it.operand_a = int'($urandom_range(0, 2 * 720 * ONE_FP)) - 720 * ONE_FP;
        end else if ((it.func == FN_ASIN || it.func == FN_ACOS) && pick < 7) begin
            it.operand_a = int'($urandom_range(0, 2 * ARC_SPAN)) - ARC_SPAN;
        end
        return it;
    endfunction

    // Presents one input transaction and returns once the block has taken it. Valid is
    // only lowered when an idle gap follows, so back-to-back transactions keep it high.
    task automatic send_item(t_in it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        results_board.note_input(it);
    endtask

    // Every transaction on the output channel is checked against the oldest prediction.
    // The values read here are those in place before the edge, as the block sees them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            results_board.check_result(o_out_item);
    end

    // The receiver stalls for a random number of cycles before each result, then waits
    // with stall low until a result is taken.
    initial begin
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        t_in directed_q[$];
        results_board = new();

        // Directed transactions cover every operation and its corner cases: mirroring of
        // vectors with negative x, the unpaired most negative value, the quadrant folds
        // including exactly 270 degrees, negative remainders, clamping, unused opcodes.
        directed_q.push_back(make_item(FN_ATAN, ONE_FP, ONE_FP));
        directed_q.push_back(make_item(FN_ATAN, ONE_FP, -ONE_FP));
        directed_q.push_back(make_item(FN_ATAN, MOST_POS, MOST_NEG));
        directed_q.push_back(make_item(FN_ATAN, 0, 0));
        directed_q.push_back(make_item(FN_MAG, MOST_NEG, MOST_NEG));
        directed_q.push_back(make_item(FN_MAG, 3 * ONE_FP, -4 * ONE_FP));
        directed_q.push_back(make_item(FN_MAG, MOST_POS, MOST_POS));
        directed_q.push_back(make_item(FN_SINCOS, 0, MOST_NEG));
        directed_q.push_back(make_item(FN_SINCOS, QUARTER_TURN, 0));
        directed_q.push_back(make_item(FN_SINCOS, QUARTER_TURN + 1, 0));
        directed_q.push_back(make_item(FN_SINCOS, THREE_QUART, 0));
        directed_q.push_back(make_item(FN_SINCOS, THREE_QUART + 1, 0));
        directed_q.push_back(make_item(FN_SINCOS, -30 * ONE_FP, 0));
        directed_q.push_back(make_item(FN_SINCOS, FULL_TURN, 0));
        directed_q.push_back(make_item(FN_SINCOS, MOST_NEG, MOST_POS));
        directed_q.push_back(make_item(FN_SINCOS, MOST_POS, 0));
        directed_q.push_back(make_item(FN_ASIN, ONE_FP, 0));
        directed_q.push_back(make_item(FN_ASIN, -ONE_FP, 0));
        directed_q.push_back(make_item(FN_ASIN, MOST_POS, 0));
        directed_q.push_back(make_item(FN_ASIN, MOST_NEG, 0));
        directed_q.push_back(make_item(FN_ACOS, ONE_FP, 0));
        directed_q.push_back(make_item(FN_ACOS, -ONE_FP, 0));
        directed_q.push_back(make_item(FN_ACOS, MOST_NEG, 0));
        directed_q.push_back(make_item(FN_ACOS + 3'd1, MOST_POS, MOST_POS));
        directed_q.push_back(make_item(FN_TOP, -1, -1));

        // Synchronous reset, held from the start and released once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[k])
            send_item(directed_q[k]);

        // Random traffic alternates between stretches with random idling on both sides
        // and stretches where the pipeline is kept completely full.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BURST_LEN == 0)
                no_idle = ((n / BURST_LEN) % 2) == 1;
            send_item(rand_item());
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        // Drain the pipeline, then allow a full latency more for stray results.
        while (results_board.pending() != 0)
            @(posedge i_clk);
        repeat (ITERS + 8) @(posedge i_clk);

        if (results_board.failures == 0)
            $display("circular_cordic_unit test passed");
        else
            $display("circular_cordic_unit test failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run of the whole stimulus.
    initial begin
        #4000000;
        $display("circular_cordic_unit test failed");
        $finish;
    end

endmodule
